// ===== hw/rtl/zcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// zcsp_pkg
// Shared constants, register indexes and types of the zoned step positioner.
// ----------------------------------------------------------------------------
package zcsp_pkg;

  localparam int ANGLE_FRACTION_BITS = 10;
  localparam int ANGLE_W             = 19;
  localparam int STEP_W              = 16;
  localparam int CFG_W               = 19;
  localparam int CFG_IDX_W           = 2;
  localparam int OFS_W               = 22;

  localparam logic [ANGLE_W-1:0] FULL_TURN   = ANGLE_W'(360 << ANGLE_FRACTION_BITS);
  localparam logic [OFS_W-1:0]   HALF_DEGREE = OFS_W'(1 << (ANGLE_FRACTION_BITS - 1));
  localparam logic [OFS_W-1:0]   ROUND_BIAS  = OFS_W'(1 << (ANGLE_FRACTION_BITS - 2));
  localparam logic [OFS_W-1:0]   ROUND_MASK  = ~(HALF_DEGREE - OFS_W'(1));

  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(1843);
  localparam logic [ANGLE_W-1:0] LOW_RESET   = ANGLE_W'(92160);
  localparam logic [ANGLE_W-1:0] HIGH_RESET  = ANGLE_W'(276480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_ANGLE = 2'd0,
    REG_LOW_LIMIT  = 2'd1,
    REG_HIGH_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               high;
    logic               clamped;
    logic [ANGLE_W-1:0] value;
  } zone_t;

endpackage

// ===== hw/rtl/zcsp_zone.sv =====
// ----------------------------------------------------------------------------
// zcsp_zone
// Zone classifier: low, high or forbidden arc, clamping by the limit midpoint.
// ----------------------------------------------------------------------------
module zcsp_zone import zcsp_pkg::*; (
  input  logic [ANGLE_W-1:0] angle,
  input  logic [ANGLE_W-1:0] low_limit,
  input  logic [ANGLE_W-1:0] high_limit,
  output zone_t              zone
);

  logic below;
  logic above;
  logic upper_half;

  assign below      = angle < low_limit;
  assign above      = (angle > high_limit) && (angle <= FULL_TURN);
  assign upper_half = {angle, 1'b0} >= ({1'b0, low_limit} + {1'b0, high_limit});

  always_comb begin
    if (below) begin
      zone = '{high: 1'b0, clamped: 1'b0, value: angle};
    end else if (above) begin
      zone = '{high: 1'b1, clamped: 1'b0, value: angle};
    end else if (upper_half) begin
      zone = '{high: 1'b1, clamped: 1'b1, value: high_limit};
    end else begin
      zone = '{high: 1'b0, clamped: 1'b1, value: low_limit};
    end
  end

endmodule

// ===== hw/rtl/zcsp_step_calc.sv =====
// ----------------------------------------------------------------------------
// zcsp_step_calc
// Offset, pulse decision and wrapped one-step position update.
// ----------------------------------------------------------------------------
module zcsp_step_calc import zcsp_pkg::*; (
  input  zone_t              target_zone,
  input  zone_t              pos_zone,
  input  logic [ANGLE_W-1:0] position,
  input  logic [STEP_W-1:0]  step_angle,
  output logic               pulse,
  output logic               direction,
  output logic [ANGLE_W-1:0] position_next
);

  logic signed [OFS_W-1:0] t;
  logic signed [OFS_W-1:0] p;
  logic signed [OFS_W-1:0] full;
  logic signed [OFS_W-1:0] diff;
  logic [OFS_W-1:0]        diff_mag;
  logic [OFS_W-1:0]        rounded;
  logic signed [OFS_W-1:0] offset;
  logic                    neg;
  logic [OFS_W-1:0]        mag;
  logic [ANGLE_W:0]        fwd_sum;
  logic [ANGLE_W:0]        back_sum;

  assign t    = $signed(OFS_W'(target_zone.value));
  assign p    = $signed(OFS_W'(position));
  assign full = $signed(OFS_W'(FULL_TURN));

  assign diff     = t - p;
  assign diff_mag = diff[OFS_W-1] ? OFS_W'(-diff) : OFS_W'(diff);
  assign rounded  = (diff_mag + ROUND_BIAS) & ROUND_MASK;

  always_comb begin
    if (target_zone.high == pos_zone.high) begin
      offset = diff[OFS_W-1] ? -$signed(rounded) : $signed(rounded);
    end else if (target_zone.high) begin
      offset = t - full - p;
    end else begin
      offset = full - p + t;
    end
  end

  assign neg       = offset[OFS_W-1];
  assign mag       = neg ? OFS_W'(-offset) : OFS_W'(offset);
  assign pulse     = {mag, 1'b0} >= (OFS_W+1)'(step_angle);
  assign direction = !(neg && pulse);

  // step is always below a full turn at this fraction width
  assign fwd_sum  = {1'b0, position} + (ANGLE_W+1)'(step_angle);
  assign back_sum = {1'b0, position} + {1'b0, FULL_TURN} - (ANGLE_W+1)'(step_angle);

  always_comb begin
    if (!pulse) begin
      position_next = position;
    end else if (neg) begin
      position_next = (back_sum >= {1'b0, FULL_TURN}) ? ANGLE_W'(back_sum - {1'b0, FULL_TURN})
                                                       : back_sum[ANGLE_W-1:0];
    end else begin
      position_next = (fwd_sum >= {1'b0, FULL_TURN}) ? ANGLE_W'(fwd_sum - {1'b0, FULL_TURN})
                                                      : fwd_sum[ANGLE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/zoned_circular_step_positioner.sv =====
// ----------------------------------------------------------------------------
// zoned_circular_step_positioner
// Clamps targets out of the forbidden arc and issues at most one step each.
//
//   channel   dir  fields
//   s_*       in   target_angle
//   m_*       out  step_pulse, step_direction, position_angle_out,
//                  target_was_clamped
//   cfg_*     in   step_angle, low_zone_limit, high_zone_limit
//
// One item per cycle unless the result side stalls; input register, then result register.
// The position loop (classify, offset, wrap) is combinational, closed by the position register.
// The input register accepts while a result waits, until both are full.
// Reset: position zero, direction one, limits and step to defaults.
// ----------------------------------------------------------------------------
module zoned_circular_step_positioner import zcsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // [18:0] target_angle
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [0] step_pulse, [1] step_direction,
                                          // [20:2] position_angle_out,
                                          // [21] target_was_clamped
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [STEP_W-1:0]  step_angle;
  logic [ANGLE_W-1:0] low_limit;
  logic [ANGLE_W-1:0] high_limit;
  logic [ANGLE_W-1:0] position;

  logic               in_valid;
  logic [ANGLE_W-1:0] in_target;
  logic               advance;

  zone_t              target_zone;
  zone_t              pos_zone;
  logic               pulse;
  logic               direction;
  logic [ANGLE_W-1:0] position_next;

  logic               out_pulse;
  logic               out_direction;
  logic [ANGLE_W-1:0] out_position;
  logic               out_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_angle <= STEP_RESET;
      low_limit  <= LOW_RESET;
      high_limit <= HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_ANGLE: step_angle <= cfg_data[STEP_W-1:0];
        REG_LOW_LIMIT:  low_limit  <= cfg_data[ANGLE_W-1:0];
        REG_HIGH_LIMIT: high_limit <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_target <= s_tdata[ANGLE_W-1:0];
    end
  end

  zcsp_zone u_target_zone (
    .angle      (in_target),
    .low_limit  (low_limit),
    .high_limit (high_limit),
    .zone       (target_zone)
  );

  zcsp_zone u_pos_zone (
    .angle      (position),
    .low_limit  (low_limit),
    .high_limit (high_limit),
    .zone       (pos_zone)
  );

  zcsp_step_calc u_step_calc (
    .target_zone   (target_zone),
    .pos_zone      (pos_zone),
    .position      (position),
    .step_angle    (step_angle),
    .pulse         (pulse),
    .direction     (direction),
    .position_next (position_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      out_direction <= 1'b1;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance) begin
        position      <= position_next;
        out_direction <= direction;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pulse    <= pulse;
      out_position <= position_next;
      out_clamped  <= target_zone.clamped;
    end
  end

  assign m_tdata = {2'b00, out_clamped, out_position, out_direction, out_pulse};

endmodule

// ===== bench/zcsp_checker.sv =====
// ----------------------------------------------------------------------------
// zcsp_checker
// Watches the target, result and register ports of the zoned step positioner,
// keeps its own copy of the limits, step and shaft position, works out the
// step, direction, new position and clamp flag of every accepted target and
// compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module zcsp_checker import zcsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [23:0]          s_tdata,   // [18:0] target_angle
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [23:0]          m_tdata,   // [0] step_pulse, [1] step_direction,
                                          // [20:2] position_angle_out,
                                          // [21] target_was_clamped
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               pulse;
    logic               dir;
    logic [ANGLE_W-1:0] pos;
    logic               clamped;
  } step_result_t;

  localparam longint TURN = longint'(FULL_TURN);
  localparam longint HALF = longint'(HALF_DEGREE);

  step_result_t       step_results_q[$];
  logic [STEP_W-1:0]  step_angle_r;
  logic [ANGLE_W-1:0] low_limit_r;
  logic [ANGLE_W-1:0] high_limit_r;
  logic [ANGLE_W-1:0] shaft_pos_r;
  logic               dir_level_r;
  int                 fail_count = 0;

  assign errors = fail_count;

  // high zone -> 1; forbidden arc and beyond a full turn snap to a limit
  function automatic logic zone_of(input longint v, output longint snapped,
                                   output logic clamped);
    longint lo;
    longint hi;
    lo = longint'(low_limit_r);
    hi = longint'(high_limit_r);
    snapped = v;
    clamped = 1'b0;
    if (v < lo) return 1'b0;
    if (v > hi && v <= TURN) return 1'b1;
    clamped = 1'b1;
    if (2 * v >= lo + hi) begin
      snapped = hi;
      return 1'b1;
    end
    snapped = lo;
    return 1'b0;
  endfunction

  // nearest half degree, ties away from zero
  function automatic longint round_half_deg(input longint d);
    longint mag;
    mag = (d < 0) ? -d : d;
    mag = ((mag + HALF / 2) / HALF) * HALF;
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic step_result_t predict_step(input logic [ANGLE_W-1:0] target);
    longint       t;
    longint       p;
    longint       p_snap;
    longint       ofs;
    longint       mag;
    longint       move;
    logic         t_high;
    logic         p_high;
    logic         clamped;
    logic         p_clamped;
    logic         pulse;
    step_result_t r;
    p = longint'(shaft_pos_r);
    t_high = zone_of(longint'(target), t, clamped);
    p_high = zone_of(p, p_snap, p_clamped);
    if (t_high == p_high)
      ofs = round_half_deg(t - p);
    else if (t_high)
      ofs = -((TURN - t) + p);
    else
      ofs = (TURN - p) + t;
    mag = (ofs < 0) ? -ofs : ofs;
    pulse = (2 * mag >= longint'(step_angle_r));
    dir_level_r = (ofs < 0 && pulse) ? 1'b0 : 1'b1;
    if (pulse) begin
      move = longint'(step_angle_r) % TURN;
      if (ofs < 0)
        p = (p + TURN - move) % TURN;
      else
        p = (p + move) % TURN;
      shaft_pos_r = ANGLE_W'(p);
    end
    r.pulse   = pulse;
    r.dir     = dir_level_r;
    r.pos     = shaft_pos_r;
    r.clamped = clamped;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    step_result_t want;
    if (rst) begin
      step_angle_r = STEP_RESET;
      low_limit_r  = LOW_RESET;
      high_limit_r = HIGH_RESET;
      shaft_pos_r  = '0;
      dir_level_r  = 1'b1;
      step_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_ANGLE: step_angle_r = cfg_data[STEP_W-1:0];
          REG_LOW_LIMIT:  low_limit_r  = cfg_data[ANGLE_W-1:0];
          REG_HIGH_LIMIT: high_limit_r = cfg_data[ANGLE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        step_results_q.push_back(predict_step(s_tdata[ANGLE_W-1:0]));
      if (m_tvalid && m_tready) begin
        if (step_results_q.size() == 0) begin
          fail_count++;
          $display("%0t result beat with nothing expected, actual tdata %h",
                   $time, m_tdata);
        end else begin
          want = step_results_q.pop_front();
          if (m_tdata[0] !== want.pulse) begin
            fail_count++;
            $display("%0t step_pulse expected %0d actual %0d",
                     $time, want.pulse, m_tdata[0]);
          end
          if (m_tdata[1] !== want.dir) begin
            fail_count++;
            $display("%0t step_direction expected %0d actual %0d",
                     $time, want.dir, m_tdata[1]);
          end
          if (m_tdata[20:2] !== want.pos) begin
            fail_count++;
            $display("%0t position_angle_out expected %0d actual %0d",
                     $time, want.pos, m_tdata[20:2]);
          end
          if (m_tdata[21] !== want.clamped) begin
            fail_count++;
            $display("%0t target_was_clamped expected %0d actual %0d",
                     $time, want.clamped, m_tdata[21]);
          end
        end
      end
    end
    pending <= step_results_q.size();
  end

endmodule

// ===== bench/tb_zoned_circular_step_positioner.sv =====
// ----------------------------------------------------------------------------
// tb_zoned_circular_step_positioner
// Drives targets through the zoned step positioner under several limit and
// step settings: a directed set at the reset values, then runs of held targets
// that walk the shaft across the zones and through zero, mixed with noise.
// Both sides idle at random; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_zoned_circular_step_positioner;

  import zcsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [ANGLE_W-1:0] lo;
    logic [ANGLE_W-1:0] hi;
  } limit_set_t;

  localparam int N_SETS   = 8;
  localparam int SET_BEATS = 229;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;   // [18:0] target_angle
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;        // [0] step_pulse, [1] step_direction,
                                        // [20:2] position_angle_out,
                                        // [21] target_was_clamped
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_ANGLE;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   errors;
  int                   pending;

  logic [ANGLE_W-1:0]   cur_lo = LOW_RESET;
  logic [ANGLE_W-1:0]   cur_hi = HIGH_RESET;
  logic [ANGLE_W-1:0]   goal = '0;
  int                   hold_left = 0;
  int                   ready_run = 0;
  logic                 ready_level = 1'b0;

  always #10 clk = ~clk;

  zoned_circular_step_positioner u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  zcsp_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // receiver stalls: short random runs, now and then a long ready stretch
  always @(posedge clk) begin
    if (ready_run == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        ready_level = 1'b1;
        ready_run   = $urandom_range(30, 80);
      end else begin
        ready_level = 1'($urandom_range(0, 1));
        ready_run   = $urandom_range(1, 10);
      end
    end
    ready_run--;
    m_tready <= ready_level;
  end

  function automatic limit_set_t limit_set(input int k);
    case (k)
      0:       return '{step: 16'd1843,  lo: 19'd92160,  hi: 19'd276480};
      1:       return '{step: 16'd1,     lo: 19'd0,      hi: 19'd368640};
      2:       return '{step: 16'd46080, lo: 19'd368640, hi: 19'd0};
      3:       return '{step: 16'd65535, lo: 19'd524287, hi: 19'd524287};
      4:       return '{step: 16'd0,     lo: 19'd100000, hi: 19'd200000};
      5:       return '{step: 16'd9216,  lo: 19'd30000,  hi: 19'd330000};
      6:       return '{step: 16'd512,   lo: 19'd180000, hi: 19'd190000};
      default: return '{step: 16'd3000,  lo: 19'd92160,  hi: 19'd276480};
    endcase
  endfunction

  task automatic send_target(input logic [ANGLE_W-1:0] t);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limits(input limit_set_t ls);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_ANGLE;
    cfg_data  <= CFG_W'(ls.step);
    @(posedge clk);
    cfg_index <= REG_LOW_LIMIT;
    cfg_data  <= ls.lo;
    @(posedge clk);
    cfg_index <= REG_HIGH_LIMIT;
    cfg_data  <= ls.hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_lo = ls.lo;
    cur_hi = ls.hi;
  endtask

  // mostly held targets so the shaft walks towards them, with noise
  function automatic logic [ANGLE_W-1:0] next_target();
    int mode;
    if (hold_left > 0 && $urandom_range(0, 6) == 0)
      return ANGLE_W'($urandom());
    if (hold_left == 0) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        goal      = ANGLE_W'($urandom_range(0, int'(FULL_TURN)));
        hold_left = $urandom_range(1, 60);
      end else if (mode == 7) begin
        goal      = ANGLE_W'($urandom_range(int'(FULL_TURN) + 1, 524287));
        hold_left = $urandom_range(1, 4);
      end else if (mode == 8) begin
        goal      = ($urandom_range(0, 1) ? cur_lo : cur_hi) +
                    ANGLE_W'($urandom_range(0, 6)) - ANGLE_W'(3);
        hold_left = $urandom_range(1, 20);
      end else begin
        goal      = ANGLE_W'($urandom());
        hold_left = 1;
      end
    end
    hold_left--;
    return goal;
  endfunction

  task automatic send_random(input int n);
    int sent;
    int burst;
    int pause;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_target(next_target());
        sent++;
      end
      pause = $urandom_range(0, 99);
      if (pause == 0) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end else if (pause < 70) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    logic [ANGLE_W-1:0] directed [20] = '{
      19'd0, 19'd255, 19'd256, 19'd767, 19'd768, 19'd921, 19'd92159, 19'd92160,
      19'd184319, 19'd184320, 19'd276480, 19'd276481, 19'd368639, 19'd368640,
      19'd368641, 19'd524287, 19'd1, 19'd200000, 19'd300000, 19'd50000
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_target(directed[i]);
    s_tvalid <= 1'b0;
    wait_drained();
    for (int k = 0; k < N_SETS; k++) begin
      repeat (4) @(posedge clk);
      write_limits(limit_set(k));
      hold_left = 0;
      send_random(SET_BEATS);
      wait_drained();
    end
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
